[sv/slc_pkg.sv]
`default_nettype none

package slc_pkg;

  localparam int CACHE_SIZE_DEF  = 4096;
  localparam int WAYS_DEF        = 2;
  localparam int LINE_BYTES_DEF  = 32;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 48;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic valid;
    logic clear;
  } slc_ctl_t;

  typedef struct packed {
    logic ready;
    logic clear_pending;
  } slc_front_t;

endpackage

`default_nettype wire

[sv/set_assoc_lru_cache_miss_counter.sv]
`default_nettype none

// Set-associative cache model with least recently used replacement and a saturating 48-bit
// miss counter. Each transfer carries either an access (cmd 0, byte address) or a clear
// (cmd 1); every transfer yields one result. Accesses are taken one per cycle unless an output
// stall, a clear in flight or the clearing pass holds the input; their results pass three address
// stages (line number, tag, set index), then the registered read of the set's row from a single
// memory of SETS rows, with the update written back while the next access reads, forwarded when
// both address the same set. After reset, and after every clear has produced its result, a clearing
// pass writes each of the SETS rows once (64 with the default sizes) while no input is taken.
// The set count and line size are reduced by exact constant division, so any sizes in range work.
module set_assoc_lru_cache_miss_counter #(
  parameter int CACHE_SIZE  = slc_pkg::CACHE_SIZE_DEF,
  parameter int WAYS        = slc_pkg::WAYS_DEF,
  parameter int LINE_BYTES  = slc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS   = slc_pkg::ADDR_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_cmd,
  input  wire [slc_pkg::ADDR_W-1:0]   in_address,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_hit,
  output logic                        out_way_used,
  output logic [slc_pkg::COUNT_W-1:0] out_miss_count
);

  localparam int ADDR_EFF = (ADDR_BITS < slc_pkg::ADDR_W) ? ADDR_BITS : slc_pkg::ADDR_W;
  localparam int RAW_SETS = CACHE_SIZE / (WAYS * LINE_BYTES);
  localparam int SETS     = (RAW_SETS == 0) ? 1 : RAW_SETS;
  localparam logic [63:0] LINE_MAX = ((64'd1 << ADDR_EFF) - 64'd1) / 64'(LINE_BYTES);
  localparam logic [63:0] TAG_MAX  = LINE_MAX / 64'(SETS);
  localparam int LINE_W   = (LINE_MAX == 64'd0) ? 1 : $clog2(LINE_MAX + 64'd1);
  localparam int TAG_W    = (TAG_MAX == 64'd0) ? 1 : $clog2(TAG_MAX + 64'd1);
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * (TAG_W + 1 + RANK_W);
  localparam int RANK_OFS = WAYS * (TAG_W + 1);

  slc_pkg::slc_front_t front;
  slc_pkg::slc_ctl_t   s2_ctl;
  logic [SET_W-1:0]    s2_set;
  logic [TAG_W-1:0]    s2_tag;

  slc_pkg::slc_ctl_t   s3_ctl_r;
  logic [SET_W-1:0]    s3_set_r;
  logic [TAG_W-1:0]    s3_tag_r;

  logic                sweep_r;
  logic                sweep_nxt;
  logic [SET_W-1:0]    sweep_cnt_r;
  logic [SET_W-1:0]    sweep_cnt_nxt;

  logic [slc_pkg::COUNT_W-1:0] miss_cnt_r;
  logic [slc_pkg::COUNT_W-1:0] miss_cnt_nxt;

  logic                out_valid_r;
  logic                out_hit_r;
  logic                out_way_r;
  logic [slc_pkg::COUNT_W-1:0] out_count_r;

  logic                move;
  logic                s3_rdy;
  logic                s3_go;
  logic                in_take;

  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    upd_row;
  logic [ROW_W-1:0]    reset_row;
  logic                upd_hit;
  logic [RANK_W-1:0]   upd_way;

  logic                wr_en;
  logic [SET_W-1:0]    wr_addr;
  logic [ROW_W-1:0]    wr_data;

  assign move    = !out_valid_r || out_ready;
  assign s3_rdy  = !s3_ctl_r.valid || move;
  assign s3_go   = s3_ctl_r.valid && move;

  assign in_ready = front.ready && !sweep_r && !front.clear_pending && !s3_ctl_r.clear;
  assign in_take  = in_valid && in_ready;

  slc_addr_split #(
    .ADDR_EFF   (ADDR_EFF),
    .LINE_BYTES (LINE_BYTES),
    .SETS       (SETS),
    .LINE_W     (LINE_W),
    .TAG_W      (TAG_W),
    .SET_W      (SET_W)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_clear (in_cmd == slc_pkg::CMD_CLEAR),
    .in_addr  (in_address[ADDR_EFF-1:0]),
    .dn_ready (s3_rdy),
    .front    (front),
    .s2_ctl   (s2_ctl),
    .s2_set   (s2_set),
    .s2_tag   (s2_tag)
  );

  slc_tag_store #(
    .SETS  (SETS),
    .SET_W (SET_W),
    .ROW_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (s3_rdy && s2_ctl.valid),
    .rd_addr (s2_set),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_row)
  );

  slc_way_update #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W),
    .ROW_W  (ROW_W)
  ) u_update (
    .row_in  (rd_row),
    .tag     (s3_tag_r),
    .row_out (upd_row),
    .hit     (upd_hit),
    .way     (upd_way)
  );

  // An empty row: no valid ways and way w holding rank w.
  always_comb begin
    reset_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      reset_row[RANK_OFS + w*RANK_W +: RANK_W] = RANK_W'(w);
    end
  end

  assign wr_en   = sweep_r || (s3_go && !s3_ctl_r.clear);
  assign wr_addr = sweep_r ? sweep_cnt_r : s3_set_r;
  assign wr_data = sweep_r ? reset_row : upd_row;

  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (s3_go && s3_ctl_r.clear) begin
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
    end else if (sweep_r) begin
      if (sweep_cnt_r == SET_W'(SETS - 1)) begin
        sweep_nxt = 1'b0;
      end else begin
        sweep_cnt_nxt = sweep_cnt_r + SET_W'(1);
      end
    end
  end

  always_comb begin
    miss_cnt_nxt = miss_cnt_r;
    if (s3_go) begin
      if (s3_ctl_r.clear) begin
        miss_cnt_nxt = '0;
      end else if (!upd_hit && (miss_cnt_r != slc_pkg::COUNT_MAX)) begin
        miss_cnt_nxt = miss_cnt_r + slc_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r    <= '0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s3_rdy) begin
        s3_ctl_r <= s2_ctl;
      end
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      if (s3_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_set_r <= s2_set;
      s3_tag_r <= s2_tag;
    end
    if (s3_go) begin
      out_hit_r   <= !s3_ctl_r.clear && upd_hit;
      out_way_r   <= !s3_ctl_r.clear && upd_way[0];
      out_count_r <= miss_cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_miss_count = out_count_r;

`ifndef SYNTHESIS
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && s3_ctl_r.clear) |=> sweep_r)
    else $error("clear did not start the clearing pass");

  a_no_lookup_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !s3_ctl_r.valid)
    else $error("lookup stage busy during the clearing pass");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && !s3_ctl_r.clear && upd_hit) |=> (miss_cnt_r == $past(miss_cnt_r)))
    else $error("miss count changed on a hit");

  a_miss_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && !s3_ctl_r.clear && !upd_hit && (miss_cnt_r != slc_pkg::COUNT_MAX))
    |=> (miss_cnt_r == $past(miss_cnt_r) + slc_pkg::COUNT_W'(1)))
    else $error("miss count did not advance by one on a miss");
`endif

endmodule

`default_nettype wire

[sv/slc_addr_split.sv]
`default_nettype none

module slc_addr_split #(
  parameter int ADDR_EFF   = 32,
  parameter int LINE_BYTES = 32,
  parameter int SETS       = 64,
  parameter int LINE_W     = 27,
  parameter int TAG_W      = 21,
  parameter int SET_W      = 6
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_take,
  input  wire                     in_clear,
  input  wire [ADDR_EFF-1:0]      in_addr,
  input  wire                     dn_ready,
  output slc_pkg::slc_front_t     front,
  output slc_pkg::slc_ctl_t       s2_ctl,
  output logic [SET_W-1:0]        s2_set,
  output logic [TAG_W-1:0]        s2_tag
);

  // Division by a constant: q = (n * M) >> K with M = ceil(2^K / d) and K = N + ceil(log2 d).
  localparam int L1  = $clog2(LINE_BYTES);
  localparam int K1  = ADDR_EFF + L1;
  localparam int PW1 = 2 * ADDR_EFF + 2;
  localparam logic [63:0] M1 =
    ((64'd1 << K1) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);

  localparam int L2  = $clog2(SETS);
  localparam int K2  = LINE_W + L2;
  localparam int PW2 = 2 * LINE_W + 2;
  localparam logic [63:0] M2 =
    ((64'd1 << K2) + 64'(SETS) - 64'd1) / 64'(SETS);

  slc_pkg::slc_ctl_t s0_ctl_r;
  slc_pkg::slc_ctl_t s1_ctl_r;
  slc_pkg::slc_ctl_t s2_ctl_r;

  logic [ADDR_EFF-1:0] s0_addr_r;
  logic [LINE_W-1:0]   s1_line_r;
  logic [LINE_W-1:0]   s2_line_r;
  logic [TAG_W-1:0]    s2_tag_r;

  logic rdy0;
  logic rdy1;
  logic rdy2;

  logic [PW1-1:0]    prod1;
  logic [PW2-1:0]    prod2;
  logic [LINE_W-1:0] line0;
  logic [TAG_W-1:0]  tag1;
  logic [LINE_W-1:0] base2;
  logic [LINE_W-1:0] rem2;

  assign rdy2 = !s2_ctl_r.valid || dn_ready;
  assign rdy1 = !s1_ctl_r.valid || rdy2;
  assign rdy0 = !s0_ctl_r.valid || rdy1;

  assign prod1 = {{(PW1 - ADDR_EFF){1'b0}}, s0_addr_r} * PW1'(M1);
  assign line0 = prod1[K1 +: LINE_W];

  assign prod2 = {{(PW2 - LINE_W){1'b0}}, s1_line_r} * PW2'(M2);
  assign tag1  = prod2[K2 +: TAG_W];

  assign base2 = LINE_W'(LINE_W'(s2_tag_r) * LINE_W'(SETS));
  assign rem2  = s2_line_r - base2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      if (rdy0) begin
        s0_ctl_r.valid <= in_take;
        s0_ctl_r.clear <= in_take && in_clear;
      end
      if (rdy1) begin
        s1_ctl_r <= s0_ctl_r;
      end
      if (rdy2) begin
        s2_ctl_r <= s1_ctl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_take) begin
      s0_addr_r <= in_addr;
    end
    if (rdy1) begin
      s1_line_r <= line0;
    end
    if (rdy2) begin
      s2_line_r <= s1_line_r;
      s2_tag_r  <= tag1;
    end
  end

  assign front.ready         = rdy0;
  assign front.clear_pending = s0_ctl_r.clear || s1_ctl_r.clear || s2_ctl_r.clear;

  assign s2_ctl = s2_ctl_r;
  assign s2_set = SET_W'(rem2);
  assign s2_tag = s2_tag_r;

endmodule

`default_nettype wire

[sv/slc_tag_store.sv]
`default_nettype none

module slc_tag_store #(
  parameter int SETS  = 64,
  parameter int SET_W = 6,
  parameter int ROW_W = 46
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              rd_en,
  input  wire [SET_W-1:0]  rd_addr,
  input  wire              wr_en,
  input  wire [SET_W-1:0]  wr_addr,
  input  wire [ROW_W-1:0]  wr_data,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_q_r;
  logic [ROW_W-1:0] byp_row_r;
  logic             byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      byp_row_r <= wr_data;
    end
  end

  // A write to the row being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_row_r : rd_q_r;

endmodule

`default_nettype wire

[sv/slc_way_update.sv]
`default_nettype none

module slc_way_update #(
  parameter int WAYS   = 2,
  parameter int TAG_W  = 21,
  parameter int RANK_W = 1,
  parameter int ROW_W  = 46
) (
  input  wire  [ROW_W-1:0]  row_in,
  input  wire  [TAG_W-1:0]  tag,
  output logic [ROW_W-1:0]  row_out,
  output logic              hit,
  output logic [RANK_W-1:0] way
);

  localparam int VLD_OFS  = WAYS * TAG_W;
  localparam int RANK_OFS = WAYS * (TAG_W + 1);

  logic [TAG_W-1:0]  tags [WAYS];
  logic              vld  [WAYS];
  logic [RANK_W-1:0] rnk  [WAYS];

  logic              found;
  logic [RANK_W-1:0] hit_way;
  logic              has_empty;
  logic [RANK_W-1:0] empty_way;
  logic [RANK_W-1:0] old_way;
  logic [RANK_W-1:0] victim;
  logic [RANK_W-1:0] vic_rank;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags[w] = row_in[w*TAG_W +: TAG_W];
      vld[w]  = row_in[VLD_OFS + w];
      rnk[w]  = row_in[RANK_OFS + w*RANK_W +: RANK_W];
    end

    found     = 1'b0;
    hit_way   = '0;
    has_empty = 1'b0;
    empty_way = '0;
    old_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld[w] && (tags[w] == tag)) begin
        found   = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (!vld[w]) begin
        has_empty = 1'b1;
        empty_way = RANK_W'(w);
      end
      if (rnk[w] == '0) begin
        old_way = RANK_W'(w);
      end
    end

    if (found) begin
      victim = hit_way;
    end else if (has_empty) begin
      victim = empty_way;
    end else begin
      victim = old_way;
    end
    vic_rank = rnk[victim];

    row_out = row_in;
    for (int w = 0; w < WAYS; w++) begin
      if (victim == RANK_W'(w)) begin
        row_out[RANK_OFS + w*RANK_W +: RANK_W] = RANK_W'(WAYS - 1);
        if (!found) begin
          row_out[w*TAG_W +: TAG_W] = tag;
          row_out[VLD_OFS + w]      = 1'b1;
        end
      end else if (rnk[w] > vic_rank) begin
        row_out[RANK_OFS + w*RANK_W +: RANK_W] = rnk[w] - RANK_W'(1);
      end
    end

    hit = found;
    way = victim;
  end

endmodule

`default_nettype wire
